/* src/fdmd_pkg.sv */
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared constants, codes and types of the frame difference motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fdmd_pkg;

  localparam int MAX_FRAME_PIXELS = 524288;
  localparam int ADDR_W = $clog2(MAX_FRAME_PIXELS);
  localparam int POS_W = ADDR_W + 1;
  localparam int CHAN_W = 8;
  localparam int PIX_W = 3 * CHAN_W;
  localparam int COUNT_W = 21;
  localparam int EVENT_W = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CHAN_W-1:0] THRESHOLD_RESET = CHAN_W'(30);
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(3072);
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [EVENT_W-1:0] EV_REF_STORED = 2'd0;
  localparam logic [EVENT_W-1:0] EV_REF_ALARM_OFF = 2'd1;
  localparam logic [EVENT_W-1:0] EV_NO_INTRUSION = 2'd2;
  localparam logic [EVENT_W-1:0] EV_INTRUSION = 2'd3;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic valid;
    logic last;
    logic compare;
    logic in_range;
  } stage_ctrl_t;

  typedef struct packed {
    logic [CHAN_W-1:0] threshold;
    logic [COUNT_W-1:0] limit;
  } cfg_t;

endpackage

`default_nettype wire

/* src/fdmd_if.sv */
// ----------------------------------------------------------------------------
// fdmd_if
// Valid/ready channels for pixel words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdmd_pixel_if;
  logic valid;
  logic ready;
  logic [fdmd_pkg::CHAN_W-1:0] red;
  logic [fdmd_pkg::CHAN_W-1:0] green;
  logic [fdmd_pkg::CHAN_W-1:0] blue;
  logic last_in_frame;

  modport source (output valid, red, green, blue, last_in_frame, input ready);
  modport sink (input valid, red, green, blue, last_in_frame, output ready);
endinterface

interface fdmd_result_if;
  logic valid;
  logic ready;
  logic [fdmd_pkg::EVENT_W-1:0] event_res;
  logic [fdmd_pkg::COUNT_W-1:0] changed_bytes;

  modport source (output valid, event_res, changed_bytes, input ready);
  modport sink (input valid, event_res, changed_bytes, output ready);
endinterface

`default_nettype wire

/* src/frame_difference_motion_detector.sv */
// ----------------------------------------------------------------------------
// frame_difference_motion_detector
// Stores a reference frame and counts changed channel bytes of the next one.
// ----------------------------------------------------------------------------
//   Channel   Dir   Handshake      Payload
//   pix       in    valid/ready    red, green, blue, last_in_frame
//   res       out   valid/ready    event_res, changed_bytes
//   apb       in    psel/penable   diff_threshold at 0x0, count_limit at 0x4
//
// One pixel word is accepted every cycle while input is not held off; each
// in-range one needs one frame memory access. A result word is formed from
// the stage holding the last pixel of its frame and registered as it advances.
// Input is held off only while the last pixel of a frame waits behind an
// earlier result word that the output has not yet taken.
// Reset does not touch the frame memory.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_difference_motion_detector (
  input  wire logic                              clk,
  input  wire logic                              rst,
  fdmd_pixel_if.sink                             pix,
  fdmd_result_if.source                          res,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fdmd_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fdmd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fdmd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  fdmd_pkg::cfg_t cfg;
  fdmd_pkg::stage_ctrl_t ctrl;
  logic advance;
  logic accept;
  logic in_range;
  logic [fdmd_pkg::POS_W-1:0] pixel_position;
  logic reference_saved;
  logic [fdmd_pkg::PIX_W-1:0] pix_word;
  logic [fdmd_pkg::PIX_W-1:0] pix_s1;
  logic [fdmd_pkg::PIX_W-1:0] stored;

  assign advance = !(ctrl.valid && ctrl.last) || !res.valid || res.ready;
  assign pix.ready = advance;
  assign accept = pix.valid && advance;
  assign in_range = !pixel_position[fdmd_pkg::POS_W-1];
  assign pix_word = {pix.red, pix.green, pix.blue};

  fdmd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdmd_frame_mem u_mem (
    .clk   (clk),
    .we    (accept && !reference_saved && in_range),
    .re    (accept && reference_saved && in_range),
    .addr  (pixel_position[fdmd_pkg::ADDR_W-1:0]),
    .wdata (pix_word),
    .rdata (stored)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      reference_saved <= 1'b0;
      ctrl <= '0;
    end else if (advance) begin
      ctrl.valid <= accept;
      if (accept) begin
        ctrl.last <= pix.last_in_frame;
        ctrl.compare <= reference_saved;
        ctrl.in_range <= in_range;
        if (pix.last_in_frame) begin
          pixel_position <= '0;
          reference_saved <= !reference_saved;
        end else if (in_range) begin
          pixel_position <= pixel_position + fdmd_pkg::POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_s1 <= pix_word;
    end
  end

  fdmd_compare u_cmp (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_ready (res.ready),
    .ctrl      (ctrl),
    .pixel     (pix_s1),
    .stored    (stored),
    .cfg       (cfg),
    .res_valid (res.valid),
    .res_event (res.event_res),
    .res_count (res.changed_bytes)
  );

endmodule

`default_nettype wire

/* src/fdmd_cfg.sv */
// ----------------------------------------------------------------------------
// fdmd_cfg
// APB register file holding the difference threshold and the count limit.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fdmd_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [fdmd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fdmd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output fdmd_pkg::cfg_t                         cfg
);

  logic [fdmd_pkg::CHAN_W-1:0] threshold;
  logic [fdmd_pkg::COUNT_W-1:0] limit;
  logic wr;

  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= fdmd_pkg::THRESHOLD_RESET;
      limit <= fdmd_pkg::LIMIT_RESET;
    end else if (wr) begin
      if (paddr[2] == fdmd_pkg::REG_THRESHOLD) begin
        threshold <= pwdata[fdmd_pkg::CHAN_W-1:0];
      end else begin
        limit <= pwdata[fdmd_pkg::COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == fdmd_pkg::REG_LIMIT) begin
      prdata = fdmd_pkg::APB_DATA_W'(limit);
    end else begin
      prdata = fdmd_pkg::APB_DATA_W'(threshold);
    end
  end

  assign cfg.threshold = threshold;
  assign cfg.limit = limit;

endmodule

`default_nettype wire

/* src/fdmd_frame_mem.sv */
// ----------------------------------------------------------------------------
// fdmd_frame_mem
// Single-port reference frame memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_frame_mem (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic                          re,
  input  wire logic [fdmd_pkg::ADDR_W-1:0]   addr,
  input  wire logic [fdmd_pkg::PIX_W-1:0]    wdata,
  output logic      [fdmd_pkg::PIX_W-1:0]    rdata
);

  logic [fdmd_pkg::PIX_W-1:0] mem [fdmd_pkg::MAX_FRAME_PIXELS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

/* src/fdmd_compare.sv */
// ----------------------------------------------------------------------------
// fdmd_compare
// Compares a pixel with its stored reference, keeps the running count and
// the alarm latch, and forms the frame event.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_compare (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           advance,
  input  wire logic                           res_ready,
  input  fdmd_pkg::stage_ctrl_t               ctrl,
  input  wire logic [fdmd_pkg::PIX_W-1:0]     pixel,
  input  wire logic [fdmd_pkg::PIX_W-1:0]     stored,
  input  fdmd_pkg::cfg_t                      cfg,
  output logic                                res_valid,
  output logic [fdmd_pkg::EVENT_W-1:0]        res_event,
  output logic [fdmd_pkg::COUNT_W-1:0]        res_count
);

  logic [fdmd_pkg::COUNT_W-1:0] running_count;
  logic [fdmd_pkg::COUNT_W-1:0] count_next;
  logic [fdmd_pkg::COUNT_W:0] count_sum;
  logic alarm_latched;
  logic [2:0] changed;
  logic [1:0] changed_n;
  logic [fdmd_pkg::CHAN_W-1:0] a;
  logic [fdmd_pkg::CHAN_W-1:0] b;
  logic [fdmd_pkg::CHAN_W-1:0] d;
  logic intrusion;

  always_comb begin
    changed = '0;
    for (int i = 0; i < 3; i++) begin
      a = pixel[i*fdmd_pkg::CHAN_W +: fdmd_pkg::CHAN_W];
      b = stored[i*fdmd_pkg::CHAN_W +: fdmd_pkg::CHAN_W];
      d = (a >= b) ? (a - b) : (b - a);
      changed[i] = (d >= cfg.threshold);
    end
    changed_n = 2'(changed[0]) + 2'(changed[1]) + 2'(changed[2]);
    count_sum = (fdmd_pkg::COUNT_W + 1)'(running_count)
              + (fdmd_pkg::COUNT_W + 1)'(changed_n);
    if (ctrl.compare && ctrl.in_range) begin
      count_next = count_sum[fdmd_pkg::COUNT_W] ? fdmd_pkg::COUNT_MAX
                                                : count_sum[fdmd_pkg::COUNT_W-1:0];
    end else begin
      count_next = running_count;
    end
    intrusion = (count_next > cfg.limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_count <= '0;
      alarm_latched <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (advance && ctrl.valid && ctrl.last) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (advance && ctrl.valid) begin
        if (ctrl.last) begin
          running_count <= '0;
          if (ctrl.compare) begin
            alarm_latched <= alarm_latched || intrusion;
          end else begin
            alarm_latched <= 1'b0;
          end
        end else begin
          running_count <= count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ctrl.valid && ctrl.last) begin
      if (ctrl.compare) begin
        res_event <= intrusion ? fdmd_pkg::EV_INTRUSION : fdmd_pkg::EV_NO_INTRUSION;
        res_count <= count_next;
      end else begin
        res_event <= alarm_latched ? fdmd_pkg::EV_REF_ALARM_OFF
                                   : fdmd_pkg::EV_REF_STORED;
        res_count <= '0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/fdmd_checker.sv */
// ----------------------------------------------------------------------------
// fdmd_checker
// Port-level checks of the frame difference motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [fdmd_pkg::EVENT_W-1:0]      out_event,
  input wire logic [fdmd_pkg::COUNT_W-1:0]      out_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_event) && $stable(out_count))
    else $error("result word changed while stalled");

  a_ref_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_event == fdmd_pkg::EV_REF_STORED ||
                  out_event == fdmd_pkg::EV_REF_ALARM_OFF) |-> out_count == '0)
    else $error("reference event carries a nonzero count");

  a_hold_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("pixel input held off with no stalled result word");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_difference_motion_detector fdmd_checker u_fdmd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix.ready),
  .out_valid (res.valid),
  .out_ready (res.ready),
  .out_event (res.event_res),
  .out_count (res.changed_bytes)
);

`default_nettype wire
